FILE: sv/swaf_pkg.sv
// ----------------------------------------------------------------------------
// swaf_pkg: shared definitions for the sliding-window anagram finder
// Field widths, request kind codes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package swaf_pkg;

  // Payload field widths
  localparam int KIND_W   = 2;
  localparam int LETTER_W = 5;
  localparam int POS_W    = 32;

  // Parameter defaults
  localparam int MAX_WINDOW_DEF = 256;
  localparam int ALPHABET_DEF   = 26;

  // Request kinds; the fourth code is unused and ignored
  typedef enum logic [KIND_W-1:0] {
    KIND_PATTERN = 2'd0,
    KIND_TEXT    = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_t;

endpackage

`default_nettype wire

FILE: sv/swaf_in_if.sv
// ----------------------------------------------------------------------------
// swaf_in_if: request channel of the anagram finder
// Valid/ready channel carrying one pattern letter, text letter or clear.
// ----------------------------------------------------------------------------
`default_nettype none

interface swaf_in_if import swaf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [LETTER_W-1:0] letter;

  modport source (output valid, output kind, output letter, input ready);
  modport sink   (input valid, input kind, input letter, output ready);
endinterface

`default_nettype wire

FILE: sv/swaf_out_if.sv
// ----------------------------------------------------------------------------
// swaf_out_if: result channel of the anagram finder
// Valid/ready channel carrying the start index of a matching window.
// ----------------------------------------------------------------------------
`default_nettype none

interface swaf_out_if import swaf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] match_start;

  modport source (output valid, output match_start, input ready);
  modport sink   (input valid, input match_start, output ready);
endinterface

`default_nettype wire

FILE: sv/sliding_window_anagram_finder.sv
// ----------------------------------------------------------------------------
// sliding_window_anagram_finder: reports every text index where the last
// pattern-length text letters are a permutation of the pattern.
//
// Requests on in_chan: a clear starts a new search, pattern letters build the
// target histogram (up to MAX_WINDOW of them), text letters stream after.
// Results on out_chan: one match_start per matching window, in text order.
// Throughput: one request per cycle unless a stall holds in_chan.ready low. The
// window's old letter is prefetched from the delay-line memory, so each text
// letter needs one read-modify-write pass over the two letter-count memories
// (two read ports, one write port each), with one-deep forwarding between
// consecutive requests. Results go from stage 1 into the result register.
// Reset (rst_n low, synchronous) empties the pipeline and the result
// register and marks every letter count as zero; no clearing pass is needed.
// When out_chan stalls, one result waits in the output register; requests
// keep flowing until a second result would be produced, then in_chan.ready
// drops until the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_anagram_finder import swaf_pkg::*; #(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int ALPHABET   = ALPHABET_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  swaf_in_if.sink    in_chan,
  swaf_out_if.source out_chan
);

  // Ring index, size counters, count memories and mismatch counter widths
  localparam int RW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int PW  = $clog2(MAX_WINDOW + 1);
  localparam int CW  = PW + 1;
  localparam int AW  = $clog2(ALPHABET);
  localparam int DFW = $clog2(ALPHABET + 1);

  typedef enum logic [1:0] {OP_NOP, OP_PAT, OP_TXT, OP_CLR} op_t;

  // The window histogram minus the target histogram per letter is kept as
  // two counts: cnt_a counts text letters entering the window, cnt_b counts
  // pattern letters plus text letters leaving it. Their difference, modulo
  // 2^CW, is exact since it stays within +/- MAX_WINDOW.

  // Search control
  logic [PW-1:0]    psize_r, psize_nxt;
  logic [PW-1:0]    fill_r, fill_nxt;
  logic [RW-1:0]    head_r, head_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             started_r, started_nxt;

  // Delay line
  logic [LETTER_W-1:0] ring_mem [MAX_WINDOW];
  logic [LETTER_W-1:0] ring_q_r;
  logic                ring_we;

  // Stage 1 request
  logic             s1_vld_r;
  op_t              s1_op_r, op_nxt;
  logic [AW-1:0]    s1_new_r, s1_old_r;
  logic             s1_rem_r, rem_nxt;
  logic             s1_rep_r, rep_nxt;
  logic [POS_W-1:0] s1_start_r;

  // Letter-count memories, valid bits and read data
  logic [CW-1:0]       cnt_a_mem [ALPHABET];
  logic [CW-1:0]       cnt_b_mem [ALPHABET];
  logic [ALPHABET-1:0] a_vld_r, b_vld_r;
  logic [CW-1:0]       a_new_q, a_old_q, b_new_q, b_old_q;

  // Forwarding of the latest write to each memory
  logic          fa_vld_r, fb_vld_r;
  logic [AW-1:0] fa_addr_r, fb_addr_r;
  logic [CW-1:0] fa_data_r, fb_data_r;

  logic [DFW-1:0] diff_r, diff_nxt;

  // Result register
  logic             out_vld_r;
  logic [POS_W-1:0] out_start_r;

  logic          accept, letter_ok, stall, s1_adv, match;
  logic [AW-1:0] in_addr, old_addr;
  logic [PW-1:0] head_p1, fill_p1;
  logic          full_before;

  logic [CW-1:0] a_n, a_o, b_n, b_o, d_n, d_o;
  logic          wa_en, wb_en;
  logic [AW-1:0] wb_addr;
  logic [CW-1:0] wa_data, wb_data;
  logic          bef_n, aft_n, bef_o, aft_o;

  assign accept    = in_chan.valid && in_chan.ready;
  assign letter_ok = 32'(in_chan.letter) < ALPHABET;
  assign in_addr   = AW'(in_chan.letter);
  assign old_addr  = AW'(ring_q_r);
  assign head_p1   = PW'(head_r) + PW'(1);
  assign fill_p1   = fill_r + PW'(1);
  assign full_before = fill_r >= psize_r;

  // Request decode and search control (head stays below psize by design)
  always_comb begin
    psize_nxt   = psize_r;
    fill_nxt    = fill_r;
    head_nxt    = head_r;
    pos_nxt     = pos_r;
    started_nxt = started_r;
    op_nxt      = OP_NOP;
    rem_nxt     = 1'b0;
    rep_nxt     = 1'b0;
    ring_we     = 1'b0;
    if (accept) begin
      unique case (in_chan.kind)
        KIND_CLEAR: begin
          psize_nxt   = '0;
          fill_nxt    = '0;
          head_nxt    = '0;
          pos_nxt     = '0;
          started_nxt = 1'b0;
          op_nxt      = OP_CLR;
        end
        KIND_PATTERN: begin
          if (letter_ok && !started_r && (32'(psize_r) < MAX_WINDOW)) begin
            psize_nxt = psize_r + PW'(1);
            op_nxt    = OP_PAT;
          end
        end
        KIND_TEXT: begin
          if (letter_ok) begin
            started_nxt = 1'b1;
            pos_nxt     = pos_r + POS_W'(1);
            if (psize_r != '0) begin
              op_nxt   = OP_TXT;
              ring_we  = 1'b1;
              head_nxt = (head_p1 >= psize_r) ? '0 : RW'(head_p1);
              rem_nxt  = full_before;
              if (!full_before) fill_nxt = fill_p1;
              rep_nxt  = full_before || (fill_p1 == psize_r);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Delay line: write the new letter, prefetch the slot the next text
  // letter will evict
  always_ff @(posedge clk) begin
    if (ring_we) ring_mem[head_r] <= in_chan.letter;
    if (ring_we && (head_nxt == head_r)) ring_q_r <= in_chan.letter;
    else                                 ring_q_r <= ring_mem[head_nxt];
  end

  // Current count values: forwarded write, memory data, or zero if unwritten
  always_comb begin
    if (fa_vld_r && (fa_addr_r == s1_new_r)) a_n = fa_data_r;
    else a_n = a_vld_r[s1_new_r] ? a_new_q : '0;
    if (fa_vld_r && (fa_addr_r == s1_old_r)) a_o = fa_data_r;
    else a_o = a_vld_r[s1_old_r] ? a_old_q : '0;
    if (fb_vld_r && (fb_addr_r == s1_new_r)) b_n = fb_data_r;
    else b_n = b_vld_r[s1_new_r] ? b_new_q : '0;
    if (fb_vld_r && (fb_addr_r == s1_old_r)) b_o = fb_data_r;
    else b_o = b_vld_r[s1_old_r] ? b_old_q : '0;
    d_n = a_n - b_n;
    d_o = a_o - b_o;
  end

  // Count updates and mismatch tracking
  always_comb begin
    wa_en   = 1'b0;
    wb_en   = 1'b0;
    wa_data = a_n + CW'(1);
    wb_addr = s1_new_r;
    wb_data = b_n + CW'(1);
    bef_n   = 1'b0;
    aft_n   = 1'b0;
    bef_o   = 1'b0;
    aft_o   = 1'b0;
    unique case (s1_op_r)
      OP_PAT: begin
        wb_en = 1'b1;
        bef_n = d_n != '0;
        aft_n = (d_n - CW'(1)) != '0;
      end
      OP_TXT: begin
        wa_en = 1'b1;
        if (s1_rem_r) begin
          wb_en   = 1'b1;
          wb_addr = s1_old_r;
          wb_data = b_o + CW'(1);
        end
        // evicting the same letter that enters leaves every difference as is
        if (!(s1_rem_r && (s1_old_r == s1_new_r))) begin
          bef_n = d_n != '0;
          aft_n = (d_n + CW'(1)) != '0;
          if (s1_rem_r) begin
            bef_o = d_o != '0;
            aft_o = (d_o - CW'(1)) != '0;
          end
        end
      end
      OP_CLR, OP_NOP: ;
      default: ;
    endcase
    if (s1_op_r == OP_CLR) diff_nxt = '0;
    else diff_nxt = diff_r + DFW'(aft_n) + DFW'(aft_o) - DFW'(bef_n) - DFW'(bef_o);
  end

  assign match  = (s1_op_r == OP_TXT) && s1_rep_r && (diff_nxt == '0);
  assign stall  = s1_vld_r && match && out_vld_r && !out_chan.ready;
  assign s1_adv = s1_vld_r && !stall;

  assign in_chan.ready        = !stall;
  assign out_chan.valid       = out_vld_r;
  assign out_chan.match_start = out_start_r;

  // Count memories: two reads at request accept, one write each from stage 1
  always_ff @(posedge clk) begin
    if (accept) begin
      a_new_q <= cnt_a_mem[in_addr];
      a_old_q <= cnt_a_mem[old_addr];
      b_new_q <= cnt_b_mem[in_addr];
      b_old_q <= cnt_b_mem[old_addr];
    end
    if (s1_adv && wa_en) cnt_a_mem[s1_new_r] <= wa_data;
    if (s1_adv && wb_en) cnt_b_mem[wb_addr]  <= wb_data;
  end

  // Stage 1 payload and forwarding data
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= op_nxt;
      s1_new_r   <= in_addr;
      s1_old_r   <= old_addr;
      s1_rem_r   <= rem_nxt;
      s1_rep_r   <= rep_nxt;
      s1_start_r <= pos_r - POS_W'(psize_r) + POS_W'(1);
    end
    if (s1_adv && wa_en) begin
      fa_addr_r <= s1_new_r;
      fa_data_r <= wa_data;
    end
    if (s1_adv && wb_en) begin
      fb_addr_r <= wb_addr;
      fb_data_r <= wb_data;
    end
    if (s1_adv && match) out_start_r <= s1_start_r;
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psize_r   <= '0;
      fill_r    <= '0;
      head_r    <= '0;
      pos_r     <= '0;
      started_r <= 1'b0;
      s1_vld_r  <= 1'b0;
      a_vld_r   <= '0;
      b_vld_r   <= '0;
      fa_vld_r  <= 1'b0;
      fb_vld_r  <= 1'b0;
      diff_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      psize_r   <= psize_nxt;
      fill_r    <= fill_nxt;
      head_r    <= head_nxt;
      pos_r     <= pos_nxt;
      started_r <= started_nxt;
      if (accept)      s1_vld_r <= 1'b1;
      else if (s1_adv) s1_vld_r <= 1'b0;
      if (s1_adv) begin
        diff_r <= diff_nxt;
        if (s1_op_r == OP_CLR) begin
          a_vld_r  <= '0;
          b_vld_r  <= '0;
          fa_vld_r <= 1'b0;
          fb_vld_r <= 1'b0;
        end else begin
          if (wa_en) begin
            a_vld_r[s1_new_r] <= 1'b1;
            fa_vld_r          <= 1'b1;
          end
          if (wb_en) begin
            b_vld_r[wb_addr] <= 1'b1;
            fb_vld_r         <= 1'b1;
          end
        end
      end
      if (s1_adv && match)     out_vld_r <= 1'b1;
      else if (out_chan.ready) out_vld_r <= 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb: testbench for the sliding-window anagram finder
// A short table of hand-picked requests goes first. Most rows carry their
// expected result, the others are checked against a behavioral model of the
// search. Random searches follow: small random patterns, then text built
// from shuffled copies of the pattern and random letters drawn from a narrow
// alphabet, plus noise. Both channel ends idle at random in phases 1 and 2 of 3.
// Every match_start that comes out is compared in order with the predicted one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb import swaf_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 9;
  localparam int RANDOM_ITEMS = 1400;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int MAX_REPORTS  = 10;
  localparam int N_DIRECTED   = 24;
  localparam int LONG_TAIL    = 20;

  // Fourth kind code, not in the package enum; the block ignores it
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  localparam logic [8:0]          WIN_MAX      = 9'(MAX_WINDOW_DEF);
  localparam logic [LETTER_W-1:0] LETTER_LIMIT = LETTER_W'(ALPHABET_DEF);

  // One request plus an optional hand-written expectation
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [LETTER_W-1:0] letter;
    bit                  preset;
    bit                  hit;
    logic [POS_W-1:0]    start;
  } search_req_t;

  // Directed requests; preset rows carry their expected result
  localparam search_req_t DIRECTED [N_DIRECTED] = '{
    '{KIND_TEXT,    5'd2,  1'b1, 1'b0, 32'd0},  // empty pattern: no result
    '{KIND_PATTERN, 5'd0,  1'b1, 1'b0, 32'd0},  // pattern after text: ignored
    '{KIND_TEXT,    5'd0,  1'b1, 1'b0, 32'd0},
    '{KIND_CLEAR,   5'd31, 1'b1, 1'b0, 32'd0},
    '{KIND_PATTERN, 5'd25, 1'b1, 1'b0, 32'd0},  // z
    '{KIND_PATTERN, 5'd0,  1'b1, 1'b0, 32'd0},  // a
    '{KIND_PATTERN, 5'd31, 1'b1, 1'b0, 32'd0},  // out of range: ignored
    '{KIND_UNUSED,  5'd31, 1'b1, 1'b0, 32'd0},  // unused kind
    '{KIND_TEXT,    5'd0,  1'b1, 1'b0, 32'd0},  // window not full yet
    '{KIND_TEXT,    5'd25, 1'b1, 1'b1, 32'd0},
    '{KIND_TEXT,    5'd0,  1'b1, 1'b1, 32'd1},
    '{KIND_TEXT,    5'd26, 1'b1, 1'b0, 32'd0},  // out of range: ignored
    '{KIND_TEXT,    5'd1,  1'b0, 1'b0, 32'd0},
    '{KIND_PATTERN, 5'd1,  1'b0, 1'b0, 32'd0},
    '{KIND_TEXT,    5'd25, 1'b0, 1'b0, 32'd0},
    '{KIND_TEXT,    5'd0,  1'b1, 1'b1, 32'd4},
    '{KIND_CLEAR,   5'd0,  1'b1, 1'b0, 32'd0},
    '{KIND_TEXT,    5'd31, 1'b1, 1'b0, 32'd0},  // ignored, text not started
    '{KIND_PATTERN, 5'd3,  1'b1, 1'b0, 32'd0},
    '{KIND_TEXT,    5'd3,  1'b1, 1'b1, 32'd0},
    '{KIND_TEXT,    5'd3,  1'b1, 1'b1, 32'd1},
    '{KIND_TEXT,    5'd16, 1'b0, 1'b0, 32'd0},
    '{KIND_CLEAR,   5'd7,  1'b1, 1'b0, 32'd0},
    '{KIND_UNUSED,  5'd0,  1'b1, 1'b0, 32'd0}
  };

  logic clk = 1'b0;
  logic rst_n;

  swaf_in_if  in_chan ();
  swaf_out_if out_chan ();

  sliding_window_anagram_finder dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #(CLK_HALF) clk = ~clk;

  search_req_t      stim_q [$];
  logic [POS_W-1:0] pending_starts [$];
  logic [4:0]       pat_q [$];
  logic [4:0]       perm_q [$];

  int err_cnt   = 0;
  int acc_cnt   = 0;
  int phase_len = 1;
  int hold_at   = 32'h7fffffff;

  // Model state: two histograms, delay line, counters
  logic [8:0]          tgt_hist [ALPHABET_DEF];
  logic [8:0]          win_hist [ALPHABET_DEF];
  logic [LETTER_W-1:0] ring [MAX_WINDOW_DEF];
  logic [8:0]          pat_len;
  logic [8:0]          ring_wr;
  logic [8:0]          win_fill;
  logic [POS_W-1:0]    txt_pos;
  logic [4:0]          diff_cnt;
  bit                  text_seen;

  function automatic void flag_error(input string msg);
    err_cnt++;
    if (err_cnt <= MAX_REPORTS) $display("ERROR: %s", msg);
  endfunction

  function automatic void clear_search();
    foreach (tgt_hist[i]) begin
      tgt_hist[i] = '0;
      win_hist[i] = '0;
    end
    pat_len   = '0;
    ring_wr   = '0;
    win_fill  = '0;
    txt_pos   = '0;
    diff_cnt  = '0;
    text_seen = 1'b0;
  endfunction

  // Moves one histogram entry and tracks how many letters disagree
  function automatic void bump_count(input bit on_target, input logic [LETTER_W-1:0] idx,
                                     input bit up);
    bit was_diff;
    bit now_diff;
    was_diff = (tgt_hist[idx] != win_hist[idx]);
    if (on_target) tgt_hist[idx] = tgt_hist[idx] + 9'd1;
    else if (up) win_hist[idx] = win_hist[idx] + 9'd1;
    else win_hist[idx] = win_hist[idx] - 9'd1;
    now_diff = (tgt_hist[idx] != win_hist[idx]);
    if (was_diff && !now_diff) diff_cnt = diff_cnt - 5'd1;
    else if (!was_diff && now_diff) diff_cnt = diff_cnt + 5'd1;
  endfunction

  // Advances the model by one request; hit tells whether a match is due
  function automatic void predict_match(input logic [KIND_W-1:0] kind,
                                        input logic [LETTER_W-1:0] letter,
                                        output bit hit, output logic [POS_W-1:0] start);
    logic [LETTER_W-1:0] oldest;
    hit   = 1'b0;
    start = '0;
    if (kind == KIND_CLEAR) begin
      clear_search();
    end else if (kind != KIND_UNUSED && letter < LETTER_LIMIT) begin
      if (kind == KIND_PATTERN) begin
        if (!text_seen && pat_len < WIN_MAX) begin
          bump_count(1'b1, letter, 1'b1);
          pat_len = pat_len + 9'd1;
        end
      end else begin
        text_seen = 1'b1;
        if (pat_len == '0) begin
          txt_pos = txt_pos + 32'd1;
        end else begin
          if (ring_wr >= pat_len) ring_wr = '0;
          // full window: the oldest letter drops out
          if (win_fill >= pat_len) begin
            oldest = ring[ring_wr[7:0]];
            bump_count(1'b0, oldest, 1'b0);
          end else begin
            win_fill = win_fill + 9'd1;
          end
          ring[ring_wr[7:0]] = letter;
          ring_wr = (ring_wr + 9'd1 >= pat_len) ? 9'd0 : ring_wr + 9'd1;
          bump_count(1'b0, letter, 1'b1);
          if (win_fill >= pat_len && diff_cnt == '0) begin
            hit   = 1'b1;
            start = txt_pos - {23'd0, pat_len} + 32'd1;
          end
          txt_pos = txt_pos + 32'd1;
        end
      end
    end
  endfunction

  function automatic void push_req(input logic [KIND_W-1:0] kind,
                                   input logic [LETTER_W-1:0] letter);
    search_req_t req;
    req = '{kind, letter, 1'b0, 1'b0, '0};
    stim_q.insert(stim_q.size(), req);
  endfunction

  // Noise request: unused kind, out-of-range letter, stray pattern or clear
  function automatic void push_noise();
    case ($urandom_range(0, 4))
      0: push_req(KIND_UNUSED, 5'($urandom_range(0, 31)));
      1: push_req(KIND_PATTERN, 5'($urandom_range(26, 31)));
      2: push_req(KIND_TEXT, 5'($urandom_range(26, 31)));
      3: push_req(KIND_PATTERN, 5'($urandom_range(0, 25)));
      default: push_req(KIND_CLEAR, 5'($urandom_range(0, 31)));
    endcase
  endfunction

  // Idle percentage per phase: sender light then heavy, receiver the reverse
  function automatic int idle_pct(input int idx, input bit rx);
    int phase;
    phase = idx / phase_len;
    if (phase == 0) return rx ? 70 : 35;
    if (phase == 1) return rx ? 35 : 70;
    return 0;
  endfunction

  // Predict on every accepted request
  always @(posedge clk) begin : accept_mon
    bit               hit;
    logic [POS_W-1:0] start;
    if (rst_n && in_chan.valid && in_chan.ready) begin
      predict_match(in_chan.kind, in_chan.letter, hit, start);
      if (acc_cnt < stim_q.size() && stim_q[acc_cnt].preset) begin
        hit   = stim_q[acc_cnt].hit;
        start = stim_q[acc_cnt].start;
      end
      if (hit) pending_starts.insert(pending_starts.size(), start);
      acc_cnt++;
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin : result_mon
    logic [POS_W-1:0] want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (pending_starts.size() == 0) begin
        flag_error($sformatf("unexpected result, match_start %0d", out_chan.match_start));
      end else begin
        want = pending_starts.pop_front();
        if (want !== out_chan.match_start)
          flag_error($sformatf("match_start: expected %0d, got %0d",
                               want, out_chan.match_start));
      end
    end
  end

  // Receiver: random ready, one long hold-off in the phase without idling
  initial begin : result_sink
    bit held;
    held = 1'b0;
    out_chan.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (!held && acc_cnt >= hold_at) begin
        held = 1'b1;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_chan.ready <= ($urandom_range(0, 99) >= idle_pct(acc_cnt, 1'b1));
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Build the request list, reset, drive, drain
  initial begin : stimulus
    int         base;
    int         span;
    int         plen;
    int         nchunk;
    int         len;
    int         pick;
    int         j;
    int         k;
    int         n_search;
    int         total;
    int         pause_at;
    bit         long_pat;
    logic [4:0] lt;
    logic [4:0] tmp;

    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.kind   <= KIND_CLEAR;
    in_chan.letter <= '0;
    clear_search();

    foreach (DIRECTED[i]) stim_q.insert(stim_q.size(), DIRECTED[i]);

    // Random searches; the third one uses an overlong pattern
    n_search = 0;
    while (stim_q.size() < N_DIRECTED + RANDOM_ITEMS) begin
      long_pat = (n_search == 2);
      if (long_pat || $urandom_range(0, 9) != 0) push_req(KIND_CLEAR, 5'($urandom_range(0, 31)));

      // narrow alphabet mostly, so windows match often
      pick = $urandom_range(0, 9);
      if (pick < 6) span = $urandom_range(2, 4);
      else if (pick < 9) span = $urandom_range(5, 10);
      else span = 26;
      base = $urandom_range(0, 26 - span);

      if (long_pat) plen = MAX_WINDOW_DEF + $urandom_range(0, 6);
      else if ($urandom_range(0, 9) < 8) plen = $urandom_range(1, 6);
      else plen = $urandom_range(0, 24);

      pat_q.delete();
      for (j = 0; j < plen; j++) begin
        if (!long_pat && $urandom_range(0, 29) == 0) push_noise();
        lt = 5'(base + $urandom_range(0, span - 1));
        push_req(KIND_PATTERN, lt);
        if (pat_q.size() < MAX_WINDOW_DEF) pat_q.insert(pat_q.size(), lt);
      end

      // text: shuffled copies of the pattern mixed with random runs
      nchunk = long_pat ? 1 : $urandom_range(2, 6);
      for (k = 0; k < nchunk; k++) begin
        if (pat_q.size() != 0 && (long_pat || $urandom_range(0, 1) == 0)) begin
          perm_q = pat_q;
          for (j = perm_q.size() - 1; j > 0; j--) begin
            pick = $urandom_range(0, j);
            tmp = perm_q[j];
            perm_q[j] = perm_q[pick];
            perm_q[pick] = tmp;
          end
          foreach (perm_q[i]) begin
            if (!long_pat && $urandom_range(0, 29) == 0) push_noise();
            push_req(KIND_TEXT, perm_q[i]);
          end
        end else begin
          len = $urandom_range(1, pat_q.size() + 2);
          repeat (len) begin
            if ($urandom_range(0, 29) == 0) push_noise();
            push_req(KIND_TEXT, 5'(base + $urandom_range(0, span - 1)));
          end
        end
      end
      if (long_pat) begin
        repeat (LONG_TAIL) push_req(KIND_TEXT, 5'(base + $urandom_range(0, span - 1)));
      end
      n_search++;
    end

    total     = stim_q.size();
    phase_len = total / 3;
    pause_at  = 2 * phase_len;
    hold_at   = pause_at + 40;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < total; i++) begin
      // sender pause: let every pending result drain first
      if (i == pause_at) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
        while (pending_starts.size() != 0) @(posedge clk);
      end
      while ($urandom_range(0, 99) < idle_pct(i, 1'b0)) begin
        in_chan.valid <= 1'b0;
        @(posedge clk);
      end
      in_chan.valid  <= 1'b1;
      in_chan.kind   <= stim_q[i].kind;
      in_chan.letter <= stim_q[i].letter;
      @(posedge clk);
      while (!in_chan.ready) @(posedge clk);
    end
    in_chan.valid <= 1'b0;

    while (pending_starts.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_starts.size() != 0)
      flag_error($sformatf("%0d predicted results never arrived", pending_starts.size()));

    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
